@@ sv/swagc_pkg.sv @@
// shared types and constants for the sliding window gain control block
`timescale 1ns / 1ps

package swagc_pkg;

  localparam int FRAC_BITS = 23;
  localparam int OUT_BITS  = 24;
  localparam int CFG_BITS  = 9;
  localparam int CNT_BITS  = 32;
  localparam int STEP_BITS = $clog2(FRAC_BITS + 1);

  localparam logic [CFG_BITS-1:0] WL_RESET = 9'd250;

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam logic [OUT_BITS-1:0] SAT_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] SAT_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef logic [OUT_BITS-1:0] out_word_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

endpackage

@@ sv/swagc_delay_ram.sv @@
// sample delay line: one write port, one registered read port
`timescale 1ns / 1ps

module swagc_delay_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/swagc_div.sv @@
// shift-subtract fraction divider with zero and saturation handling
`timescale 1ns / 1ps

module swagc_div #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  swagc_pkg::div_ctl_t                        ctl,
  input  logic [SAMPLE_BITS-1:0]                     mag,
  input  logic [SAMPLE_BITS+swagc_pkg::CFG_BITS-1:0] divisor,
  output logic                                       busy,
  output swagc_pkg::out_word_t                       result
);

  localparam int SUM_BITS = SAMPLE_BITS + swagc_pkg::CFG_BITS;
  localparam int FB = swagc_pkg::FRAC_BITS;
  localparam int SB = swagc_pkg::STEP_BITS;

  logic                 busy_r, busy_nxt;
  logic [SB-1:0]        step_r, step_nxt;
  logic [SUM_BITS-1:0]  rem_r, rem_nxt;
  logic [SUM_BITS-1:0]  div_r, div_nxt;
  logic [FB-1:0]        quo_r, quo_nxt;
  logic                 neg_r, neg_nxt;
  swagc_pkg::out_word_t res_r, res_nxt;

  logic [SUM_BITS:0]    shifted;
  logic                 ge;
  logic [SUM_BITS-1:0]  mag_ext;
  swagc_pkg::out_word_t q_ext;

  assign shifted = {rem_r, 1'b0};
  assign ge      = shifted >= {1'b0, div_r};
  assign mag_ext = SUM_BITS'(mag);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    q_ext    = '0;
    if (ctl.start) begin
      div_nxt = divisor;
      neg_nxt = ctl.neg;
      rem_nxt = mag_ext;
      quo_nxt = '0;
      step_nxt = SB'(FB);
      if (divisor == '0) begin
        res_nxt  = '0;
        busy_nxt = 1'b0;
      end else if (mag_ext >= divisor) begin
        // quotient reaches one: clamp
        res_nxt  = ctl.neg ? swagc_pkg::SAT_NEG : swagc_pkg::SAT_POS;
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? SUM_BITS'(shifted - {1'b0, div_r}) : SUM_BITS'(shifted);
      quo_nxt  = {quo_r[FB-2:0], ge};
      step_nxt = step_r - SB'(1);
      if (step_r == SB'(1)) begin
        busy_nxt = 1'b0;
        q_ext    = {1'b0, quo_r[FB-2:0], ge};
        res_nxt  = neg_r ? (~q_ext + swagc_pkg::out_word_t'(1)) : q_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

  assign busy   = busy_r;
  assign result = res_r;

endmodule

@@ sv/sliding_window_agc.sv @@
// top level: sliding window gain control with sequencer, delay line and divider
//
//   port group  dir  handshake         payload
//   in_         in   in_valid/ready    in_func, in_sample
//   out_        out  out_valid/ready   out_scaled, out_last
//   cfg_        in   cfg_we            cfg_data (window length)
//
// a result for a push or a drain passes two memory reads, 23 divider steps and the
// output load before it shows on out_valid; a zero or clamped quotient skips the
// steps. an item with no result returns to idle from the check state (push) or from
// the execute state (drain, or push while draining); in_ready is high only in idle.
// synchronous reset clears counters, window sum and drain flag and loads window
// length 250. a pending result stalls the sequencer in its final state until taken.
`timescale 1ns / 1ps

module sliding_window_agc #(
  parameter int MAX_WINDOW  = 512,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swagc_pkg::OUT_BITS-1:0] out_scaled,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [swagc_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int AW       = $clog2(MAX_WINDOW);
  localparam int SUM_BITS = SAMPLE_BITS + swagc_pkg::CFG_BITS;
  localparam int CB       = swagc_pkg::CNT_BITS;
  localparam int HMAX     = (MAX_WINDOW - 1) / 2;
  localparam int HW       = $clog2(HMAX + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_CHECK, S_RD_X, S_RD_OLD, S_SUB, S_DIV, S_OUT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [swagc_pkg::CFG_BITS-1:0] wl_r;
  logic                          func_r, func_nxt;
  logic [SAMPLE_BITS-1:0]        samp_r, samp_nxt;
  logic [SUM_BITS-1:0]           sum_r, sum_nxt;
  logic [CB-1:0]                 rcv_r, rcv_nxt;
  logic [CB-1:0]                 emt_r, emt_nxt;
  logic [AW-1:0]                 wptr_r, wptr_nxt;
  logic [AW-1:0]                 rptr_r, rptr_nxt;
  logic                          drain_r, drain_nxt;
  logic                          last_r, last_nxt;
  logic                          ovalid_r, ovalid_nxt;
  swagc_pkg::out_word_t          oscaled_r, oscaled_nxt;
  logic                          olast_r, olast_nxt;

  logic [HW-1:0]                 h;
  logic [swagc_pkg::CFG_BITS-2:0] wl_half;
  logic [AW:0]                   old_diff;
  logic [AW-1:0]                 old_slot;
  logic [AW-1:0]                 raddr;
  logic                          ram_we;
  logic [SAMPLE_BITS-1:0]        rdata;
  logic [SAMPLE_BITS-1:0]        mag_in;
  logic [SAMPLE_BITS-1:0]        mag_rd;
  swagc_pkg::div_ctl_t           div_ctl;
  logic                          div_busy;
  swagc_pkg::out_word_t          div_res;

  assign wl_half = wl_r[swagc_pkg::CFG_BITS-1:1];
  assign h = (32'(wl_half) > HMAX) ? HW'(HMAX) : HW'(wl_half);

  // slot of the sample leaving the window, modulo the delay line depth
  assign old_diff = {1'b0, rptr_r} - (AW+1)'(h);
  assign old_slot = old_diff[AW] ? AW'(old_diff + (AW+1)'(MAX_WINDOW)) : old_diff[AW-1:0];

  assign mag_in = samp_r[SAMPLE_BITS-1] ? (~samp_r + SAMPLE_BITS'(1)) : samp_r;
  assign mag_rd = rdata[SAMPLE_BITS-1] ? (~rdata + SAMPLE_BITS'(1)) : rdata;

  assign ram_we = (state_r == S_EXEC) && (func_r == swagc_pkg::FUNC_PUSH) && !drain_r;
  assign raddr  = (state_r == S_RD_OLD) ? old_slot : rptr_r;

  assign div_ctl.start = (state_r == S_RD_OLD);
  assign div_ctl.neg   = rdata[SAMPLE_BITS-1];

  swagc_delay_ram #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (samp_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  swagc_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .mag     (mag_rd),
    .divisor (sum_r),
    .busy    (div_busy),
    .result  (div_res)
  );

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    samp_nxt    = samp_r;
    sum_nxt     = sum_r;
    rcv_nxt     = rcv_r;
    emt_nxt     = emt_r;
    wptr_nxt    = wptr_r;
    rptr_nxt    = rptr_r;
    drain_nxt   = drain_r;
    last_nxt    = last_r;
    ovalid_nxt  = ovalid_r;
    oscaled_nxt = oscaled_r;
    olast_nxt   = olast_r;

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          samp_nxt  = in_sample;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (func_r == swagc_pkg::FUNC_PUSH) begin
          if (drain_r) begin
            state_nxt = S_IDLE;
          end else begin
            sum_nxt   = sum_r + SUM_BITS'(mag_in);
            rcv_nxt   = rcv_r + CB'(1);
            wptr_nxt  = (wptr_r == AW'(MAX_WINDOW - 1)) ? '0 : wptr_r + AW'(1);
            state_nxt = S_CHECK;
          end
        end else if (rcv_r == '0) begin
          drain_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else if (rcv_r == emt_r) begin
          sum_nxt   = '0;
          rcv_nxt   = '0;
          emt_nxt   = '0;
          wptr_nxt  = '0;
          rptr_nxt  = '0;
          drain_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          drain_nxt = 1'b1;
          last_nxt  = (emt_r + CB'(1)) == rcv_r;
          state_nxt = S_RD_X;
        end
      end
      S_CHECK: begin
        last_nxt  = 1'b0;
        state_nxt = ((rcv_r - emt_r) > CB'(h)) ? S_RD_X : S_IDLE;
      end
      S_RD_X: begin
        state_nxt = S_RD_OLD;
      end
      S_RD_OLD: begin
        state_nxt = S_SUB;
      end
      S_SUB: begin
        // divider already holds the old sum; slide the lower edge now
        if (emt_r >= CB'(h)) begin
          sum_nxt = sum_r - SUM_BITS'(mag_rd);
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt  = 1'b1;
          oscaled_nxt = div_res;
          olast_nxt   = last_r;
          emt_nxt     = emt_r + CB'(1);
          rptr_nxt    = (rptr_r == AW'(MAX_WINDOW - 1)) ? '0 : rptr_r + AW'(1);
          if (last_r) begin
            sum_nxt   = '0;
            rcv_nxt   = '0;
            emt_nxt   = '0;
            wptr_nxt  = '0;
            rptr_nxt  = '0;
            drain_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wl_r     <= swagc_pkg::WL_RESET;
      sum_r    <= '0;
      rcv_r    <= '0;
      emt_r    <= '0;
      wptr_r   <= '0;
      rptr_r   <= '0;
      drain_r  <= 1'b0;
      last_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        wl_r <= cfg_data;
      end
      sum_r    <= sum_nxt;
      rcv_r    <= rcv_nxt;
      emt_r    <= emt_nxt;
      wptr_r   <= wptr_nxt;
      rptr_r   <= rptr_nxt;
      drain_r  <= drain_nxt;
      last_r   <= last_nxt;
      ovalid_r <= ovalid_nxt;
    end
    func_r    <= func_nxt;
    samp_r    <= samp_nxt;
    oscaled_r <= oscaled_nxt;
    olast_r   <= olast_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = ovalid_r;
  assign out_scaled = oscaled_r;
  assign out_last   = olast_r;

endmodule

@@ sv/swagc_checker.sv @@
// port-level checks for the sliding window gain control block, with bind
`timescale 1ns / 1ps

module swagc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [swagc_pkg::OUT_BITS-1:0] out_scaled,
  input logic                           out_last
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scaled) && $stable(out_last))
    else $error("result changed or dropped while stalled");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in progress");

  // a fresh result is loaded only from the busy final step
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready) && in_ready)
    else $error("result appeared outside of a processing run");

endmodule

bind sliding_window_agc swagc_checker u_swagc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_scaled (out_scaled),
  .out_last   (out_last)
);
